>>> sv/itr_pkg.sv
`default_nettype none
package itr_pkg;

   localparam int ValueWidth  = 12;
   localparam int SymbolWidth = 7;
   localparam int DigitWidth  = 4;
   localparam int NumDigits   = 4;
   localparam int PosWidth    = 2;
   localparam int LenWidth    = 3;

   localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

   typedef logic [ValueWidth-1:0]         value_type;
   typedef logic [SymbolWidth-1:0]        symbol_type;
   typedef logic [DigitWidth-1:0]         digit_type;
   typedef logic [PosWidth-1:0]           pos_type;
   typedef logic [LenWidth-1:0]           len_type;
   typedef digit_type [NumDigits-1:0]     digits_type;

   // digit positions, most significant first
   localparam pos_type PosThousands = 2'd0;
   localparam pos_type PosHundreds  = 2'd1;
   localparam pos_type PosTens      = 2'd2;
   localparam pos_type PosUnits     = 2'd3;

   // ascii codes of the numeral letters
   localparam symbol_type SymI    = 7'h49;
   localparam symbol_type SymV    = 7'h56;
   localparam symbol_type SymX    = 7'h58;
   localparam symbol_type SymL    = 7'h4C;
   localparam symbol_type SymC    = 7'h43;
   localparam symbol_type SymD    = 7'h44;
   localparam symbol_type SymM    = 7'h4D;
   localparam symbol_type SymNone = 7'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXTRACT,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic start;
      logic load_error;
   } emit_ctrl_type;

   typedef struct packed {
      logic out_free;
      logic done;
   } emit_status_type;

   // place value of a digit position (units handled apart)
   function automatic value_type digit_weight(input pos_type pos);
      value_type w;
      case (pos)
         PosThousands: w = 12'd1000;
         PosHundreds:  w = 12'd100;
         PosTens:      w = 12'd10;
         default:      w = 12'd1;
      endcase
      return w;
   endfunction

   // characters needed for one decimal digit
   function automatic len_type digit_len(input digit_type d);
      len_type n;
      case (d)
         4'd1, 4'd5:             n = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
         4'd3, 4'd7:             n = 3'd3;
         4'd8:                   n = 3'd4;
         default:                n = 3'd0;
      endcase
      return n;
   endfunction

   // k-th character of digit d at position pos
   function automatic symbol_type roman_sym(input pos_type pos, input digit_type d,
                                            input logic [PosWidth-1:0] k);
      symbol_type one;
      symbol_type five;
      symbol_type ten;
      symbol_type s;
      case (pos)
         PosThousands: begin one = SymM; five = SymNone; ten = SymNone; end
         PosHundreds:  begin one = SymC; five = SymD;    ten = SymM;    end
         PosTens:      begin one = SymX; five = SymL;    ten = SymC;    end
         default:      begin one = SymI; five = SymV;    ten = SymX;    end
      endcase
      if (d == 4'd9) begin
         s = (k == 2'd0) ? one : ten;
      end else if (d == 4'd4) begin
         s = (k == 2'd0) ? one : five;
      end else if (d inside {[4'd5:4'd8]}) begin
         s = (k == 2'd0) ? five : one;
      end else begin
         s = one;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

>>> sv/itr_extract.sv
`default_nettype none
module itr_extract (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire itr_pkg::value_type  value,
   output      logic                done,
   output      itr_pkg::digits_type digits
);
   import itr_pkg::*;

   logic       run_ff, run_in;
   value_type  rem_ff, rem_in;
   pos_type    pos_ff, pos_in;
   digits_type digits_ff, digits_in;
   value_type  weight;
   logic       fits;

   // shared compare and subtract against the current place value
   assign weight = digit_weight(pos_ff);
   assign fits   = (rem_ff >= weight);
   assign done   = run_ff && (pos_ff == PosUnits);
   assign digits = digits_ff;

   always_comb begin
      run_in    = run_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      digits_in = digits_ff;
      if (start) begin
         run_in    = 1'b1;
         rem_in    = value;
         pos_in    = PosThousands;
         digits_in = '0;
      end else if (run_ff) begin
         if (pos_ff == PosUnits) begin
            digits_in[PosUnits] = rem_ff[DigitWidth-1:0];
            run_in              = 1'b0;
         end else if (fits) begin
            rem_in            = rem_ff - weight;
            digits_in[pos_ff] = digits_ff[pos_ff] + 4'd1;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      rem_ff    <= rem_in;
      pos_ff    <= pos_in;
      digits_ff <= digits_in;
   end

endmodule
`default_nettype wire

>>> sv/itr_emit.sv
`default_nettype none
module itr_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire itr_pkg::emit_ctrl_type  ctrl,
   input  wire itr_pkg::digits_type     digits,
   output      itr_pkg::emit_status_type status,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      itr_pkg::symbol_type     rsp_symbol,
   output      logic                    rsp_last,
   output      logic                    rsp_range_error
);
   import itr_pkg::*;

   logic       busy_ff, busy_in;
   pos_type    pos_ff, pos_in;
   pos_type    k_ff, k_in;
   logic       valid_ff, valid_in;
   symbol_type sym_ff, sym_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   logic       out_free;
   digit_type  cur_digit;
   len_type    cur_len;
   logic       last_char;
   logic       rest_zero;
   logic       final_char;

   assign out_free   = !valid_ff || rsp_ready;
   assign cur_digit  = digits[pos_ff];
   assign cur_len    = digit_len(cur_digit);
   assign last_char  = (({1'b0, k_ff} + 3'd1) == cur_len);

   // no nonzero digit follows the current one
   always_comb begin
      rest_zero = 1'b1;
      for (int i = 0; i < NumDigits; i++) begin
         if (i > int'(pos_ff) && digits[i] != '0) begin
            rest_zero = 1'b0;
         end
      end
   end

   assign final_char = (cur_len != '0) && last_char && rest_zero;

   assign status.out_free = out_free;
   assign status.done     = busy_ff && out_free && final_char;

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      k_in     = k_ff;
      valid_in = valid_ff && !rsp_ready;
      sym_in   = sym_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         pos_in  = PosThousands;
         k_in    = '0;
      end else if (ctrl.load_error && out_free) begin
         valid_in = 1'b1;
         sym_in   = SymNone;
         last_in  = 1'b1;
         err_in   = 1'b1;
      end else if (busy_ff && out_free) begin
         if (cur_len != '0) begin
            valid_in = 1'b1;
            sym_in   = roman_sym(pos_ff, cur_digit, k_ff);
            last_in  = final_char;
            err_in   = 1'b0;
         end
         if (final_char) begin
            busy_in = 1'b0;
         end else if (cur_len == '0 || last_char) begin
            pos_in = pos_ff + 2'd1;
            k_in   = '0;
         end else begin
            k_in = k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      k_ff    <= k_in;
      sym_ff  <= sym_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_symbol      = sym_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = err_ff;

endmodule
`default_nettype wire

>>> sv/integer_to_roman_numeral.sv
`default_nettype none
// channel   | ports                                      | carries
// ----------+--------------------------------------------+------------------------------
// request   | req_valid req_ready req_value[11:0]        | one integer per transfer
// response  | rsp_valid rsp_ready rsp_symbol[6:0]        | one ascii letter per transfer,
//           | rsp_last rsp_range_error                   | last on the final letter
//
// an item is accepted, then split into digits in the subtract loop, one
// compare-subtract per cycle, then streamed out one letter at a time, with
// each zero digit before the final letter passed over without a letter
// zero or above 3999 goes to the error state; its single error transfer is
// made valid once the output register is free
// req_ready is high only when the sequencer is idle
// a stalled rsp holds the emitter; the last letter may still wait while the
// next integer is taken and its digits are extracted
// reset is synchronous and clears the sequencer and the response valid
module integer_to_roman_numeral (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire itr_pkg::value_type  req_value,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      itr_pkg::symbol_type rsp_symbol,
   output      logic                rsp_last,
   output      logic                rsp_range_error
);
   import itr_pkg::*;

   state_type       state_ff, state_in;
   logic            req_xfer;
   logic            bad_value;
   logic            ext_start;
   logic            ext_done;
   digits_type      digits;
   emit_ctrl_type   emit_ctrl;
   emit_status_type emit_status;

   assign req_xfer  = req_valid && req_ready;
   // outside 1..3999 goes straight to the error response
   assign bad_value = (req_value == '0) || (req_value > MaxValue);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: take item, split into digits, stream letters, or flag a bad value
   always_comb begin
      state_in             = state_ff;
      req_ready            = 1'b0;
      ext_start            = 1'b0;
      emit_ctrl.start      = 1'b0;
      emit_ctrl.load_error = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               if (bad_value) begin
                  state_in = ST_ERROR;
               end else begin
                  ext_start = 1'b1;
                  state_in  = ST_EXTRACT;
               end
            end
         end
         ST_EXTRACT: begin
            // the units digit is written at the same edge that starts the emitter
            if (ext_done) begin
               emit_ctrl.start = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_status.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: begin
            // wait for a free output register
            emit_ctrl.load_error = 1'b1;
            if (emit_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // repeated compare-subtract by 1000, 100, 10
   itr_extract u_extract (
      .clock  (clock),
      .reset  (reset),
      .start  (ext_start),
      .value  (req_value),
      .done   (ext_done),
      .digits (digits)
   );

   // letter stream with output register
   itr_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (emit_ctrl),
      .digits          (digits),
      .status          (emit_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

endmodule
`default_nettype wire
